// ===== src/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSV converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package rhc_pkg;

    localparam int CH_W      = 8;   // colour channel width
    localparam int HUE_W     = 15;  // hue field width
    localparam int SAT_W     = 16;  // saturation field width (Q1.15)
    localparam int DIV_W     = 9;   // divisor width: 2*max or 2*delta
    localparam int DIV_STEPS = 4;   // quotient bits resolved per divider stage
    localparam int SAT_SHIFT = 16;  // 2 * 32768 as a shift
    localparam int SAT_MIN_Q = 16;  // quotient bits saturation needs
    localparam int HUE_INT_Q = 9;   // quotient bits of whole degrees (< 512)
    localparam int NUM_W     = 18;  // signed hue numerator, degrees times delta
    localparam int HUE_G_DEG = 120;
    localparam int HUE_B_DEG = 240;
    localparam int HUE_SLOPE = 60;
    localparam int HUE_WRAP  = 360;

    // Which channel is the largest; red wins ties, then green.
    typedef enum logic [2:0] {
        SEL_RED   = 3'b001,
        SEL_GREEN = 3'b010,
        SEL_BLUE  = 3'b100
    } rhc_sel_t;

    // Side information that travels with each pixel through the divider.
    typedef struct packed {
        logic [CH_W-1:0] value;
        logic            sat_zero;
        logic            hue_zero;
    } rhc_side_t;

endpackage

`default_nettype wire

// ===== src/rhc_front.sv =====
// Front end: max/min/delta and sector pick, then the dividends and divisors.
// Two register stages with valid/ready; depends on rhc_pkg.
`default_nettype none

module rhc_front import rhc_pkg::*; #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int QW            = 16
) (
    input  wire  logic             aclk,
    input  wire  logic             aresetn,
    input  wire  logic             in_valid,
    output logic                   in_ready,
    input  wire  logic [CH_W-1:0]  red,
    input  wire  logic [CH_W-1:0]  green,
    input  wire  logic [CH_W-1:0]  blue,
    output logic                   out_valid,
    input  wire  logic             out_ready,
    output rhc_side_t              out_side,
    output logic [DIV_W-1:0]       out_rem_s,
    output logic [QW-1:0]          out_q_s,
    output logic [DIV_W-1:0]       out_den_s,
    output logic [DIV_W-1:0]       out_rem_h,
    output logic [QW-1:0]          out_q_h,
    output logic [DIV_W-1:0]       out_den_h
);

    localparam int NW = QW + DIV_W;

    // stage A
    logic                    va_reg;
    logic [CH_W-1:0]         mx_reg;
    logic [CH_W-1:0]         d_reg;
    rhc_sel_t                sel_reg;
    logic signed [CH_W:0]    diff_reg;
    logic                    a_ready;

    logic [CH_W-1:0]         mx_rg, mx_next, mn_rg, mn_next;
    rhc_sel_t                sel_next;
    logic signed [CH_W:0]    diff_next;

    // stage B
    logic                    vb_reg;
    logic                    b_ready;
    logic signed [NUM_W-1:0] base_term, diff_term, num_raw, num_w;
    logic [NUM_W-2:0]        num_u;
    logic [NW-1:0]           n_sat, n_hue;

    assign b_ready  = !vb_reg || out_ready;
    assign a_ready  = !va_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        mx_rg     = (red >= green) ? red : green;
        mx_next   = (mx_rg >= blue) ? mx_rg : blue;
        mn_rg     = (red <= green) ? red : green;
        mn_next   = (mn_rg <= blue) ? mn_rg : blue;
        if (red == mx_next) begin
            sel_next  = SEL_RED;
            diff_next = $signed({1'b0, green}) - $signed({1'b0, blue});
        end else if (green == mx_next) begin
            sel_next  = SEL_GREEN;
            diff_next = $signed({1'b0, blue}) - $signed({1'b0, red});
        end else begin
            sel_next  = SEL_BLUE;
            diff_next = $signed({1'b0, red}) - $signed({1'b0, green});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (a_ready) begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && a_ready) begin
            mx_reg   <= mx_next;
            d_reg    <= mx_next - mn_next;
            sel_reg  <= sel_next;
            diff_reg <= diff_next;
        end
    end

    // Hue numerator in degrees times delta, wrapped into [0, 360*delta)
    always_comb begin
        unique case (sel_reg)
            SEL_RED:   base_term = '0;
            SEL_GREEN: base_term = NUM_W'(HUE_G_DEG) * NUM_W'(d_reg);
            SEL_BLUE:  base_term = NUM_W'(HUE_B_DEG) * NUM_W'(d_reg);
            default:   base_term = '0;
        endcase
        diff_term = {{(NUM_W-CH_W-1){diff_reg[CH_W]}}, diff_reg} * NUM_W'(HUE_SLOPE);
        num_raw   = base_term + diff_term;
        if (num_raw[NUM_W-1]) begin
            num_w = num_raw + NUM_W'(HUE_WRAP) * NUM_W'(d_reg);
        end else begin
            num_w = num_raw;
        end
        num_u = num_w[NUM_W-2:0];
        // round to nearest: (2*num*2^F + d) / (2*d)
        n_hue = (NW'(num_u) << (HUE_FRAC_BITS + 1)) + NW'(d_reg);
        // (2*d*32768 + max) / (2*max)
        n_sat = (NW'(d_reg) << SAT_SHIFT) + NW'(mx_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (b_ready) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (va_reg && b_ready) begin
            out_side.value    <= mx_reg;
            out_side.sat_zero <= (mx_reg == '0);
            out_side.hue_zero <= (d_reg == '0);
            out_rem_s         <= n_sat[NW-1:QW];
            out_q_s           <= n_sat[QW-1:0];
            out_den_s         <= {mx_reg, 1'b0};
            out_rem_h         <= n_hue[NW-1:QW];
            out_q_h           <= n_hue[QW-1:0];
            out_den_h         <= {d_reg, 1'b0};
        end
    end

    assign out_valid = vb_reg;

endmodule

`default_nettype wire

// ===== src/rhc_div_lane.sv =====
// A few restoring-division steps: one quotient bit per step.
// Combinational; depends on rhc_pkg.
`default_nettype none

module rhc_div_lane import rhc_pkg::*; #(
    parameter int QW = 16
) (
    input  wire  logic [DIV_W-1:0] rem_in,
    input  wire  logic [QW-1:0]    q_in,
    input  wire  logic [DIV_W-1:0] den,
    output logic [DIV_W-1:0]       rem_out,
    output logic [QW-1:0]          q_out
);

    // q holds the dividend bits still to come on top and quotient bits below
    always_comb begin : p_steps
        logic [DIV_W:0]   t;
        logic [DIV_W-1:0] r;
        logic [QW-1:0]    qq;
        logic             qbit;
        r  = rem_in;
        qq = q_in;
        for (int i = 0; i < DIV_STEPS; i++) begin
            t = {r, qq[QW-1]};
            if (t >= {1'b0, den}) begin
                r    = DIV_W'(t - {1'b0, den});
                qbit = 1'b1;
            end else begin
                r    = t[DIV_W-1:0];
                qbit = 1'b0;
            end
            qq = {qq[QW-2:0], qbit};
        end
        rem_out = r;
        q_out   = qq;
    end

endmodule

`default_nettype wire

// ===== src/rhc_div_stage.sv =====
// One register stage of the two pipelined dividers (saturation and hue).
// Depends on rhc_pkg and rhc_div_lane.
`default_nettype none

module rhc_div_stage import rhc_pkg::*; #(
    parameter int QW = 16
) (
    input  wire  logic             aclk,
    input  wire  logic             aresetn,
    input  wire  logic             in_valid,
    output logic                   in_ready,
    input  wire  rhc_side_t        in_side,
    input  wire  logic [DIV_W-1:0] in_rem_s,
    input  wire  logic [QW-1:0]    in_q_s,
    input  wire  logic [DIV_W-1:0] in_den_s,
    input  wire  logic [DIV_W-1:0] in_rem_h,
    input  wire  logic [QW-1:0]    in_q_h,
    input  wire  logic [DIV_W-1:0] in_den_h,
    output logic                   out_valid,
    input  wire  logic             out_ready,
    output rhc_side_t              out_side,
    output logic [DIV_W-1:0]       out_rem_s,
    output logic [QW-1:0]          out_q_s,
    output logic [DIV_W-1:0]       out_den_s,
    output logic [DIV_W-1:0]       out_rem_h,
    output logic [QW-1:0]          out_q_h,
    output logic [DIV_W-1:0]       out_den_h
);

    logic             v_reg;
    logic [DIV_W-1:0] rem_s_next, rem_h_next;
    logic [QW-1:0]    q_s_next, q_h_next;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;

    rhc_div_lane #(.QW(QW)) u_sat (
        .rem_in  (in_rem_s),
        .q_in    (in_q_s),
        .den     (in_den_s),
        .rem_out (rem_s_next),
        .q_out   (q_s_next)
    );

    rhc_div_lane #(.QW(QW)) u_hue (
        .rem_in  (in_rem_h),
        .q_in    (in_q_h),
        .den     (in_den_h),
        .rem_out (rem_h_next),
        .q_out   (q_h_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            out_side  <= in_side;
            out_rem_s <= rem_s_next;
            out_q_s   <= q_s_next;
            out_den_s <= in_den_s;
            out_rem_h <= rem_h_next;
            out_q_h   <= q_h_next;
            out_den_h <= in_den_h;
        end
    end

endmodule

`default_nettype wire

// ===== src/rgb_to_hsv_converter.sv =====
// RGB to HSV converter, top level: front end, divider pipeline, output register.
// Depends on rhc_pkg, rhc_front and rhc_div_stage.
//
// Usage:
//   Input stream s_axis_*: one pixel per request, red/green/blue in tdata.
//   Output stream m_axis_*: hue (1/2^HUE_FRAC_BITS degree), saturation (Q1.15)
//   and value, one result per pixel, in input order.
//   Throughput is one pixel per cycle when the receiver keeps tready high.
//   A request passes the front-end registers, then NSTAGE =
//   ceil(max(16, 9 + HUE_FRAC_BITS) / 4) divider stages, each resolving four
//   quotient bits of both divisions, then the output register.
//   Each stage has its own valid bit and stalls only when the next one is
//   full, so bubbles are squeezed out while m_axis_tready is low; once the
//   pipeline is full s_axis_tready drops and nothing is lost or repeated.
//   Synchronous reset (aresetn low) empties every stage; no results are
//   pending afterwards.
`default_nettype none

module rgb_to_hsv_converter import rhc_pkg::*; #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  wire  logic        aclk,
    input  wire  logic        aresetn,
    input  wire  logic        s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic              m_axis_tvalid,
    input  wire  logic        m_axis_tready,
    output logic [39:0]       m_axis_tdata    // hue[14:0], saturation[30:15],
                                              // value[38:31], zero[39]
);

    localparam int QW_MIN = (HUE_FRAC_BITS + HUE_INT_Q > SAT_MIN_Q) ?
                            HUE_FRAC_BITS + HUE_INT_Q : SAT_MIN_Q;
    localparam int NSTAGE = (QW_MIN + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QW     = NSTAGE * DIV_STEPS;

    logic             vld [NSTAGE+1];
    logic             rdy [NSTAGE+1];
    rhc_side_t        side [NSTAGE+1];
    logic [DIV_W-1:0] rem_s [NSTAGE+1];
    logic [QW-1:0]    q_s   [NSTAGE+1];
    logic [DIV_W-1:0] den_s [NSTAGE+1];
    logic [DIV_W-1:0] rem_h [NSTAGE+1];
    logic [QW-1:0]    q_h   [NSTAGE+1];
    logic [DIV_W-1:0] den_h [NSTAGE+1];

    logic             m_valid_reg;
    logic [HUE_W-1:0] hue_reg;
    logic [SAT_W-1:0] sat_reg;
    logic [CH_W-1:0]  value_reg;

    rhc_front #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .QW            (QW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .red       (s_axis_tdata[7:0]),
        .green     (s_axis_tdata[15:8]),
        .blue      (s_axis_tdata[23:16]),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_side  (side[0]),
        .out_rem_s (rem_s[0]),
        .out_q_s   (q_s[0]),
        .out_den_s (den_s[0]),
        .out_rem_h (rem_h[0]),
        .out_q_h   (q_h[0]),
        .out_den_h (den_h[0])
    );

    for (genvar k = 0; k < NSTAGE; k++) begin : g_div
        rhc_div_stage #(.QW(QW)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[k]),
            .in_ready  (rdy[k]),
            .in_side   (side[k]),
            .in_rem_s  (rem_s[k]),
            .in_q_s    (q_s[k]),
            .in_den_s  (den_s[k]),
            .in_rem_h  (rem_h[k]),
            .in_q_h    (q_h[k]),
            .in_den_h  (den_h[k]),
            .out_valid (vld[k+1]),
            .out_ready (rdy[k+1]),
            .out_side  (side[k+1]),
            .out_rem_s (rem_s[k+1]),
            .out_q_s   (q_s[k+1]),
            .out_den_s (den_s[k+1]),
            .out_rem_h (rem_h[k+1]),
            .out_q_h   (q_h[k+1]),
            .out_den_h (den_h[k+1])
        );
    end

    assign rdy[NSTAGE] = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy[NSTAGE]) begin
            m_valid_reg <= vld[NSTAGE];
        end
    end

    // black and grey pixels: the divisor was zero, so the quotient is masked
    always_ff @(posedge aclk) begin
        if (vld[NSTAGE] && rdy[NSTAGE]) begin
            hue_reg   <= side[NSTAGE].hue_zero ? '0 : q_h[NSTAGE][HUE_W-1:0];
            sat_reg   <= side[NSTAGE].sat_zero ? '0 : q_s[NSTAGE][SAT_W-1:0];
            value_reg <= side[NSTAGE].value;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, value_reg, sat_reg, hue_reg};

endmodule

`default_nettype wire

// ===== src/rhc_checker.sv =====
// Port-level checks for the RGB to HSV converter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module rhc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result request dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // zero saturation only for black or grey pixels, whose hue is zero
    a_grey_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[30:15] == 16'd0) |-> (m_axis_tdata[14:0] == 15'd0))
        else $error("non-zero hue with zero saturation");

    // saturation never exceeds 1.0 and the padding bit is clear
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[30:15] <= 16'd32768) && !m_axis_tdata[39])
        else $error("saturation out of range");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
